/* design/p16fma_pkg.sv */
`default_nettype none
package p16fma_pkg;
    localparam int DataW = 16;
    localparam logic [15:0] NaR = 16'h8000;
    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_SUB = 2'd1;
    localparam logic [1:0] KIND_NMUL = 2'd2;

    typedef struct packed {
        logic        special;
        logic [15:0] special_val;
        logic        sz;
        logic        sc;
        logic        c_zero;
        logic signed [6:0] ka;
        logic        ea;
        logic signed [6:0] kc;
        logic        ec;
        logic [15:0] fc;
    } t_dec;

    function automatic logic [15:0] neg16(input logic [15:0] v);
        neg16 = 16'(~v + 16'd1);
    endfunction

    // regime k and the bits after the regime, exponent at bit 14
    function automatic logic [22:0] split_posit(input logic [15:0] u);
        logic [15:0] t;
        logic signed [6:0] r;
        logic run;
        t = 16'(u << 2);
        run = 1'b1;
        if (u[14]) begin
            r = 7'sd0;
            for (int i = 0; i < 16; i++) begin
                if (run && t[15]) begin
                    r = 7'(r + 7'sd1);
                    t = 16'(t << 1);
                end else begin
                    run = 1'b0;
                end
            end
        end else begin
            r = -7'sd1;
            for (int i = 0; i < 16; i++) begin
                if (run && !t[15] && t != 16'd0) begin
                    r = 7'(r - 7'sd1);
                    t = 16'(t << 1);
                end else begin
                    run = 1'b0;
                end
            end
            t = t & 16'h7FFF;
        end
        split_posit = {r, t};
    endfunction
endpackage
`default_nettype wire

/* design/posit16_fused_multiply_add.sv */
`default_nettype none
// Posit16 (es=1) fused multiply-add: o_result = a*b+c, a*b-c or -(a*b)+c by i_kind,
// rounded once to nearest even. Fully pipelined: a transaction is taken in every
// cycle (busy is always low) and its result appears on o_result with o_done high
// after it has passed the input register and the stages decode and product, align and
// add, renormalise, pack and round. There is no back-pressure; the
// receiver must take each result in the cycle it is shown.
module posit16_fused_multiply_add (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_kind,
    input  wire logic [15:0] i_operand_a,
    input  wire logic [15:0] i_operand_b,
    input  wire logic [15:0] i_addend_c,
    output logic             o_done,
    output logic [15:0]      o_result
);
    logic v1, v3, done3, sz3, ez3, st3;
    p16fma_pkg::t_dec dec1;
    logic [31:0] z1, z3;
    logic [15:0] dv3;
    logic signed [7:0] kz3;
    logic r_vin;
    logic [1:0] r_kind;
    logic [15:0] r_a, r_b, r_c;

    assign busy = 1'b0;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vin <= 1'b0;
        end else begin
            r_vin <= start;
        end
        r_kind <= i_kind;
        r_a <= i_operand_a;
        r_b <= i_operand_b;
        r_c <= i_addend_c;
    end

    p16fma_decode u_dec (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_vin), .i_kind(r_kind),
        .i_a(r_a), .i_b(r_b), .i_c(r_c), .o_valid(v1), .o_dec(dec1), .o_z(z1)
    );

    p16fma_add u_add (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v1), .i_dec(dec1), .i_z(z1),
        .o_valid(v3), .o_done(done3), .o_done_val(dv3), .o_sz(sz3), .o_kz(kz3),
        .o_ez(ez3), .o_z(z3), .o_sticky(st3)
    );

    p16fma_round u_rnd (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v3), .i_done(done3),
        .i_done_val(dv3), .i_sz(sz3), .i_kz(kz3), .i_ez(ez3), .i_z(z3),
        .i_sticky(st3), .o_valid(o_done), .o_result(o_result)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##5 o_done) else $error("result missing");
    a_nar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && (i_operand_b == p16fma_pkg::NaR)) |-> ##5 (o_result == p16fma_pkg::NaR))
        else $error("NaR not propagated");
    a_nodone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |-> ##5 !o_done) else $error("spurious result");
endmodule
`default_nettype wire

/* design/p16fma_decode.sv */
`default_nettype none
// stage 1: specials, sign handling, regime decode, significand product
module p16fma_decode (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [1:0]  i_kind,
    input  wire logic [15:0] i_a,
    input  wire logic [15:0] i_b,
    input  wire logic [15:0] i_c,
    output logic             o_valid,
    output p16fma_pkg::t_dec o_dec,
    output logic [31:0]      o_z
);
    logic [15:0] a, b, c, ma, mb, mc;
    logic [22:0] spa, spb, spc;
    logic [15:0] fa, fb;
    p16fma_pkg::t_dec n_dec;
    p16fma_pkg::t_dec r_dec;
    logic [31:0] r_z;
    logic r_valid;
    logic [1:0] esum;

    always_comb begin
        a = (i_kind == p16fma_pkg::KIND_NMUL) ? p16fma_pkg::neg16(i_a) : i_a;
        b = i_b;
        c = (i_kind == p16fma_pkg::KIND_SUB) ? p16fma_pkg::neg16(i_c) : i_c;
        ma = a[15] ? p16fma_pkg::neg16(a) : a;
        mb = b[15] ? p16fma_pkg::neg16(b) : b;
        mc = c[15] ? p16fma_pkg::neg16(c) : c;
        spa = p16fma_pkg::split_posit(ma);
        spb = p16fma_pkg::split_posit(mb);
        spc = p16fma_pkg::split_posit(mc);
        // hidden bit at 15, fraction below it, exponent bit dropped
        fa = {1'b1, spa[13:0], 1'b0};
        fb = {1'b1, spb[13:0], 1'b0};
        esum = {1'b0, spa[14]} + {1'b0, spb[14]};
        n_dec.special = 1'b0;
        n_dec.special_val = c;
        if (a == p16fma_pkg::NaR || b == p16fma_pkg::NaR || c == p16fma_pkg::NaR) begin
            n_dec.special = 1'b1;
            n_dec.special_val = p16fma_pkg::NaR;
        end else if (a == 16'd0 || b == 16'd0) begin
            n_dec.special = 1'b1;
        end
        n_dec.sz = a[15] ^ b[15];
        n_dec.sc = c[15];
        n_dec.c_zero = (c == 16'd0);
        n_dec.ka = 7'(spa[22:16] + spb[22:16] + (esum[1] ? 7'sd1 : 7'sd0));
        n_dec.ea = esum[0];
        n_dec.kc = spc[22:16];
        n_dec.ec = spc[14];
        n_dec.fc = {2'b01, spc[13:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_dec <= n_dec;
        r_z <= fa * fb;
    end

    assign o_valid = r_valid;
    assign o_dec = r_dec;
    assign o_z = r_z;
endmodule
`default_nettype wire

/* design/p16fma_add.sv */
`default_nettype none
// stages 2 and 3: product normalise, align and add; then renormalise
module p16fma_add (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire p16fma_pkg::t_dec i_dec,
    input  wire logic [31:0] i_z,
    output logic             o_valid,
    output logic             o_done,
    output logic [15:0]      o_done_val,
    output logic             o_sz,
    output logic signed [7:0] o_kz,
    output logic             o_ez,
    output logic [31:0]      o_z,
    output logic             o_sticky
);
    // stage 2 combinational
    logic signed [6:0] ka;
    logic ea;
    logic [31:0] zp;
    logic [31:0] fc;
    logic signed [8:0] sr;
    logic [5:0] sh;
    logic big;
    logic [32:0] sum;
    logic sticky, sz, done;
    logic [15:0] done_val;
    logic signed [6:0] kz;
    logic ez;

    logic r_valid, r_done, r_sticky, r_sz, r_ez, r_zero_c;
    logic [15:0] r_done_val;
    logic signed [6:0] r_kz;
    logic [32:0] r_sum;

    always_comb begin
        ka = i_dec.ka;
        ea = i_dec.ea;
        zp = i_z;
        if (i_z[31]) begin
            if (ea) ka = 7'(ka + 7'sd1);
            ea = ~ea;
            zp = i_z >> 1;
        end
        fc = {i_dec.fc, 16'd0};
        sr = 9'(($signed({ka[6], ka}) - $signed({i_dec.kc[6], i_dec.kc})) * 2)
             + $signed({8'd0, ea}) - $signed({8'd0, i_dec.ec});
        sticky = 1'b0;
        sz = i_dec.sz;
        done = i_dec.special;
        done_val = i_dec.special_val;
        kz = ka;
        ez = ea;
        sum = {1'b0, zp};
        big = 1'b0;
        sh = 6'd0;
        if (!i_dec.c_zero) begin
            if (sr < 0) begin
                big = (-sr) >= 9'sd31;
                sh = big ? 6'd0 : 6'(-sr);
                sticky = big ? 1'b1 : ((zp << (6'd32 - sh)) != 32'd0);
                sum = {1'b0, big ? 32'd0 : (zp >> sh)};
                if (sz == i_dec.sc) begin
                    sum = 33'({1'b0, fc} + sum);
                end else begin
                    sum = 33'({1'b0, fc} - sum - {32'd0, sticky});
                    sz = i_dec.sc;
                end
                kz = i_dec.kc;
                ez = i_dec.ec;
            end else if (sr > 0) begin
                big = sr >= 9'sd31;
                sh = big ? 6'd0 : 6'(sr);
                sticky = big ? 1'b1 : ((fc << (6'd32 - sh)) != 32'd0);
                sum = {1'b0, big ? 32'd0 : (fc >> sh)};
                if (sz == i_dec.sc) sum = 33'({1'b0, zp} + sum);
                else sum = 33'({1'b0, zp} - sum - {32'd0, sticky});
            end else begin
                if (sz == i_dec.sc) begin
                    sum = 33'({1'b0, zp} + {1'b0, fc});
                end else if (zp < fc) begin
                    sum = {1'b0, fc - zp};
                    sz = i_dec.sc;
                end else begin
                    sum = {1'b0, zp - fc};
                end
            end
            if (!done && sum[31:0] == 32'd0) begin
                done = 1'b1;
                done_val = 16'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_done <= done;
        r_done_val <= done_val;
        r_sticky <= sticky;
        r_sz <= sz;
        r_kz <= kz;
        r_ez <= ez;
        r_sum <= sum;
        r_zero_c <= i_dec.c_zero;
    end

    // stage 3: renormalise
    logic [31:0] z3;
    logic signed [7:0] k3;
    logic e3, s3;
    logic [4:0] lz;
    logic [31:0] sv;

    always_comb begin
        z3 = r_sum[31:0];
        k3 = {r_kz[6], r_kz};
        e3 = r_ez;
        s3 = r_sticky;
        lz = 5'd0;
        sv = 32'd0;
        if (!r_zero_c) begin
            if (z3[31]) begin
                if (e3) k3 = 8'(k3 + 8'sd1);
                e3 = ~e3;
                if (z3[0]) s3 = 1'b1;
                z3 = z3 >> 1;
            end else begin
                // leading-zero count over bits 30..0; the shift is applied in pairs
                for (int i = 30; i >= 0; i--) begin
                    if (z3[i] && lz == 5'd0 && sv == 32'd0) begin
                        lz = 5'(30 - i);
                        sv = 32'd1;
                    end
                end
                k3 = 8'(k3 - $signed({4'd0, lz[4:1]}));
                z3 = z3 << {lz[4:1], 1'b0};
                if (!z3[30]) begin
                    if (!e3) k3 = 8'(k3 - 8'sd1);
                    e3 = ~e3;
                    z3 = z3 << 1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_valid;
        end
        o_done <= r_done;
        o_done_val <= r_done_val;
        o_sz <= r_sz;
        o_kz <= k3;
        o_ez <= e3;
        o_z <= z3;
        o_sticky <= s3;
    end
endmodule
`default_nettype wire

/* design/p16fma_round.sv */
`default_nettype none
// stage 4: pack regime, exponent and fraction, round to nearest even
module p16fma_round (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_done,
    input  wire logic [15:0] i_done_val,
    input  wire logic        i_sz,
    input  wire logic signed [7:0] i_kz,
    input  wire logic        i_ez,
    input  wire logic [31:0] i_z,
    input  wire logic        i_sticky,
    output logic             o_valid,
    output logic [15:0]      o_result
);
    logic [3:0] rz;
    logic [15:0] regime, res, fz;
    logic [29:0] z;
    logic nplus, sticky, sat;
    logic [15:0] satv;
    logic [15:0] n_res;

    always_comb begin
        sat = 1'b0;
        satv = 16'd0;
        rz = 4'd1;
        regime = 16'd0;
        if (i_kz < 0) begin
            if (-i_kz > 8'sd14) begin
                sat = 1'b1;
                satv = 16'h0001;
            end else begin
                rz = 4'(-i_kz);
                regime = 16'h4000 >> rz;
            end
        end else begin
            if (i_kz + 8'sd1 > 8'sd14) begin
                sat = 1'b1;
                satv = 16'h7FFF;
            end else begin
                rz = 4'(i_kz + 8'sd1);
                regime = 16'h7FFF - (16'h7FFF >> rz);
            end
        end
        z = i_z[29:0];
        sticky = i_sticky;
        nplus = 1'b0;
        fz = 16'(z >> (5'd17 + 5'(rz)));
        if (rz != 4'd14) begin
            nplus = z[16 + rz];
        end else if (z != 30'd0) begin
            fz = 16'd0;
            sticky = 1'b1;
        end
        if (rz == 4'd14 && i_ez) nplus = 1'b1;
        res = 16'(regime + ((rz < 4'd14) ? (16'(i_ez) << (4'd13 - rz)) : 16'd0) + fz);
        if (nplus) begin
            if (32'({2'b0, z} << (5'd16 - 5'(rz))) != 32'd0) sticky = 1'b1;
            res = 16'(res + {15'd0, res[0] | sticky});
        end
        if (sat) res = satv;
        if (i_sz) res = p16fma_pkg::neg16(res);
        n_res = i_done ? i_done_val : res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
        o_result <= n_res;
    end
endmodule
`default_nettype wire
